FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while out of reset.
`define PACS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define PACS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pacs_pkg.sv
// Shared types and constants for the PNG alpha chunk sniffer.
// No dependencies; used by every module of the block.
package pacs_pkg;

  localparam int unsigned OFFSET_W = 34;
  localparam int unsigned SKIP_W   = 33;

  // Walker phases.
  localparam logic [1:0] PH_SIG  = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_IHDR = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;

  // Verdict codes.
  localparam logic [1:0] V_UNKNOWN = 2'd0;
  localparam logic [1:0] V_ABSENT  = 2'd1;
  localparam logic [1:0] V_PRESENT = 2'd2;

  // Chunk types as big-endian ASCII.
  localparam logic [31:0] KIND_IHDR = 32'h4948_4452;
  localparam logic [31:0] KIND_TRNS = 32'h7452_4E53;
  localparam logic [31:0] KIND_IDAT = 32'h4944_4154;
  localparam logic [31:0] KIND_IEND = 32'h4945_4E44;

  localparam logic [31:0] IHDR_LEN     = 32'd13;
  localparam logic [7:0]  CT_GREY_A    = 8'd4;
  localparam logic [7:0]  CT_RGBA      = 8'd6;
  localparam logic [32:0] CRC_BYTES    = 33'd4;

  localparam logic [7:0] PNG_MAGIC [8] = '{
    8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
  };

  // Configuration register indexes and reset values.
  localparam logic REG_MAX_CHUNKS = 1'b0;
  localparam logic REG_MAX_OFFSET = 1'b1;
  localparam logic [15:0] MAX_CHUNKS_RST = 16'd4096;
  localparam logic [31:0] MAX_OFFSET_RST = 32'd67108864;

  typedef struct packed {
    logic       valid;
    logic [1:0] verdict;
  } pacs_result_t;

endpackage

FILE: rtl/png_alpha_chunk_sniffer.sv
// PNG alpha sniffer top level: configuration registers, chunk walker, result buffer.
// Depends on pacs_pkg, pacs_walker and pacs_outbuf.
//
// The block takes one byte of a PNG file per clock cycle, with in_end_of_file
// marking the last byte, and returns one verdict per file (0 unknown, 1 absent,
// 2 present). Each byte is handled by a state update in the chunk walker, so a
// new byte is accepted every cycle while in_stall is low; the deciding byte's
// verdict is registered in the output register, or behind it in the skid entry.
// A two-entry output buffer holds verdicts while the downstream side stalls, and
// in_stall rises only when both entries are occupied. Bytes after the verdict are
// swallowed until the end-of-file byte. The limit registers sit at byte addresses
// 0 (max_chunks) and 4 (max_header_offset) and should be written between files.
module png_alpha_chunk_sniffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_verdict,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pacs_pkg::*;

  logic [15:0]  max_chunks_r;
  logic [31:0]  max_offset_r;
  logic         cfg_write;
  logic         in_fire;
  logic         buf_full;
  pacs_result_t result;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Only the word address is decoded; byte offsets within a word alias.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chunks_r <= MAX_CHUNKS_RST;
      max_offset_r <= MAX_OFFSET_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_MAX_CHUNKS) begin
        max_chunks_r <= pwdata[15:0];
      end else begin
        max_offset_r <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_MAX_OFFSET) ? max_offset_r : {16'd0, max_chunks_r};

  assign in_stall = buf_full;
  assign in_fire  = in_valid && !buf_full;

  pacs_walker u_walker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_fire           (in_fire),
    .data_byte         (in_data_byte),
    .end_of_file       (in_end_of_file),
    .max_chunks        (max_chunks_r),
    .max_header_offset (max_offset_r),
    .result            (result)
  );

  pacs_outbuf u_outbuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (result),
    .full        (buf_full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_verdict (out_verdict)
  );

endmodule

FILE: rtl/pacs_walker.sv
// Per-byte PNG signature check and chunk walk; produces at most one verdict per file.
// Depends on pacs_pkg.
module pacs_walker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_file,
  input  logic [15:0]          max_chunks,
  input  logic [31:0]          max_header_offset,
  output pacs_pkg::pacs_result_t result
);
  import pacs_pkg::*;

  logic [1:0]          phase_r, phase_nxt;
  logic [3:0]          bip_r, bip_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [SKIP_W-1:0]   skip_r, skip_nxt;
  logic [31:0]         len_r, len_nxt;
  logic [31:0]         kind_r, kind_nxt;
  logic [15:0]         count_r, count_nxt;
  logic [7:0]          colour_r, colour_nxt;
  logic                given_r, given_nxt;

  logic                enter_fail;
  logic                decided;
  logic [1:0]          verdict;
  logic [SKIP_W-1:0]   skip_dec;

  always_comb begin
    phase_nxt  = phase_r;
    bip_nxt    = bip_r;
    offset_nxt = offset_r;
    skip_nxt   = skip_r;
    len_nxt    = len_r;
    kind_nxt   = kind_r;
    count_nxt  = count_r;
    colour_nxt = colour_r;
    given_nxt  = given_r;
    decided    = 1'b0;
    verdict    = V_UNKNOWN;
    enter_fail = 1'b0;
    skip_dec   = skip_r;

    if (in_fire && !given_r) begin
      offset_nxt = offset_r + OFFSET_W'(1);
      // A new chunk header is checked against both limits at its starting offset.
      enter_fail = (count_r >= max_chunks) ||
                   (offset_nxt > {{(OFFSET_W - 32){1'b0}}, max_header_offset});

      unique case (phase_r)
        PH_SIG: begin
          if (data_byte != PNG_MAGIC[bip_r[2:0]]) begin
            decided = 1'b1;
          end else begin
            bip_nxt = bip_r + 4'd1;
            if (bip_r == 4'd7) begin
              if (enter_fail) begin
                decided = 1'b1;
              end else begin
                count_nxt = count_r + 16'd1;
                phase_nxt = PH_HDR;
                bip_nxt   = 4'd0;
                len_nxt   = '0;
                kind_nxt  = '0;
              end
            end
          end
        end
        PH_HDR: begin
          if (bip_r < 4'd4) begin
            len_nxt = {len_r[23:0], data_byte};
          end else begin
            kind_nxt = {kind_r[23:0], data_byte};
          end
          bip_nxt = bip_r + 4'd1;
          if (bip_r == 4'd7) begin
            priority if (kind_nxt == KIND_IHDR) begin
              if (len_nxt != IHDR_LEN) begin
                decided = 1'b1;
              end else begin
                phase_nxt = PH_IHDR;
                bip_nxt   = 4'd0;
              end
            end else if (kind_nxt == KIND_TRNS) begin
              decided = 1'b1;
              verdict = (len_nxt != 32'd0) ? V_PRESENT : V_UNKNOWN;
            end else if (kind_nxt == KIND_IDAT || kind_nxt == KIND_IEND) begin
              decided = 1'b1;
              verdict = V_ABSENT;
            end else begin
              phase_nxt = PH_SKIP;
              skip_nxt  = {1'b0, len_nxt} + CRC_BYTES;
            end
          end
        end
        PH_IHDR: begin
          if (bip_r == 4'd9) begin
            colour_nxt = data_byte;
          end
          bip_nxt = bip_r + 4'd1;
          if (bip_r == 4'd12) begin
            if (colour_nxt == CT_GREY_A || colour_nxt == CT_RGBA) begin
              decided = 1'b1;
              verdict = V_PRESENT;
            end else begin
              phase_nxt = PH_SKIP;
              skip_nxt  = CRC_BYTES;
            end
          end
        end
        PH_SKIP: begin
          if (skip_r != '0) begin
            skip_dec = skip_r - SKIP_W'(1);
          end
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            if (enter_fail) begin
              decided = 1'b1;
            end else begin
              count_nxt = count_r + 16'd1;
              phase_nxt = PH_HDR;
              bip_nxt   = 4'd0;
              len_nxt   = '0;
              kind_nxt  = '0;
            end
          end
        end
      endcase

      // Truncated file: the end mark arrives before anything was decided.
      if (!decided && end_of_file) begin
        decided = 1'b1;
        verdict = V_UNKNOWN;
      end
      given_nxt = decided;
    end

    if (in_fire && end_of_file) begin
      phase_nxt  = PH_SIG;
      bip_nxt    = '0;
      offset_nxt = '0;
      skip_nxt   = '0;
      len_nxt    = '0;
      kind_nxt   = '0;
      count_nxt  = '0;
      colour_nxt = '0;
      given_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIG;
      bip_r    <= '0;
      offset_r <= '0;
      skip_r   <= '0;
      len_r    <= '0;
      kind_r   <= '0;
      count_r  <= '0;
      colour_r <= '0;
      given_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      bip_r    <= bip_nxt;
      offset_r <= offset_nxt;
      skip_r   <= skip_nxt;
      len_r    <= len_nxt;
      kind_r   <= kind_nxt;
      count_r  <= count_nxt;
      colour_r <= colour_nxt;
      given_r  <= given_nxt;
    end
  end

  assign result.valid   = decided;
  assign result.verdict = verdict;

endmodule

FILE: rtl/pacs_outbuf.sv
// Two-entry result buffer: an output register backed by a skid register.
// Depends on pacs_pkg.
module pacs_outbuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pacs_pkg::pacs_result_t push,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_verdict
);
  import pacs_pkg::*;

  logic       main_v_r, main_v_nxt;
  logic [1:0] main_d_r, main_d_nxt;
  logic       skid_v_r, skid_v_nxt;
  logic [1:0] skid_d_r, skid_d_nxt;
  logic       pop;

  assign pop = main_v_r && !out_stall;

  // A push only arrives while the skid register is empty, since full stalls the input.
  always_comb begin
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (pop) begin
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (!main_v_r || pop) begin
      main_v_nxt = push.valid;
      main_d_nxt = push.verdict;
    end else if (push.valid) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push.verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign full        = skid_v_r;
  assign out_valid   = main_v_r;
  assign out_verdict = main_d_r;

endmodule

FILE: rtl/pacs_checker.sv
// Port-level checks on the PNG alpha sniffer, bound to the top level.
// Depends on assert_macros.svh and png_alpha_chunk_sniffer.
`include "assert_macros.svh"

module pacs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_verdict
);

  // A stalled verdict stays put.
  `PACS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_verdict), "verdict changed under stall")

  // The input can only be held off while a verdict waits on a stalled output.
  `PACS_ASSERT(a_stall_needs_out, in_stall |-> out_valid, "input stalled with empty output")

  `PACS_ASSERT(a_stall_cause, in_stall |-> $past(out_valid && out_stall), "input stalled without output stall")

  `PACS_ASSERT(a_verdict_code, out_valid |-> out_verdict != 2'd3, "illegal verdict code")

  `PACS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "not idle after reset")

endmodule

bind png_alpha_chunk_sniffer pacs_checker u_pacs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_verdict (out_verdict)
);

FILE: sim/tb_png_alpha_chunk_sniffer.sv
`timescale 1ns / 1ps
// Self-checking testbench for png_alpha_chunk_sniffer: streams PNG-like byte files,
// predicts one alpha verdict per file and compares every verdict the block returns.
// Depends on pacs_pkg and the png_alpha_chunk_sniffer RTL only.
module tb_png_alpha_chunk_sniffer;
  import pacs_pkg::*;

  localparam logic [7:0] CT_TRUECOLOUR = 8'd2;

  // Walks each file as the block should and keeps the verdicts still owed.
  class alpha_verdict_board;
    logic [15:0] chunk_limit;
    logic [31:0] offset_limit;
    logic [1:0]  walk;
    int unsigned pos;
    logic [33:0] offset;
    logic [32:0] skip_left;
    logic [31:0] chunk_len;
    logic [31:0] chunk_kind;
    logic [15:0] headers;
    logic [7:0]  colour;
    bit          decided;
    logic [1:0]  pending_verdicts[$];
    int          mismatches;
    int          bytes_walked;
    int          verdicts_seen;
    int          tally[3];

    function new();
      chunk_limit  = MAX_CHUNKS_RST;
      offset_limit = MAX_OFFSET_RST;
      clear_file();
    endfunction

    function void clear_file();
      walk       = PH_SIG;
      pos        = 0;
      offset     = '0;
      skip_left  = '0;
      chunk_len  = '0;
      chunk_kind = '0;
      headers    = '0;
      colour     = '0;
      decided    = 1'b0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == REG_MAX_CHUNKS) begin
        chunk_limit = value[15:0];
      end else begin
        offset_limit = value;
      end
    endfunction

    function void give(logic [1:0] v);
      decided = 1'b1;
      pending_verdicts.push_back(v);
      tally[v]++;
    endfunction

    // Limits are checked just before a chunk header would begin.
    function void open_header();
      if (headers >= chunk_limit || offset > {2'b00, offset_limit}) begin
        give(V_UNKNOWN);
      end else begin
        headers    = headers + 16'd1;
        walk       = PH_HDR;
        pos        = 0;
        chunk_len  = '0;
        chunk_kind = '0;
      end
    endfunction

    function void close_header();
      if (chunk_kind == KIND_IHDR) begin
        if (chunk_len != IHDR_LEN) begin
          give(V_UNKNOWN);
        end else begin
          walk = PH_IHDR;
          pos  = 0;
        end
      end else if (chunk_kind == KIND_TRNS) begin
        give(chunk_len != 32'd0 ? V_PRESENT : V_UNKNOWN);
      end else if (chunk_kind == KIND_IDAT || chunk_kind == KIND_IEND) begin
        give(V_ABSENT);
      end else begin
        walk      = PH_SKIP;
        skip_left = {1'b0, chunk_len} + CRC_BYTES;
      end
    endfunction

    function void walk_byte(logic [7:0] b);
      offset = offset + 34'd1;
      case (walk)
        PH_SIG: begin
          if (b != PNG_MAGIC[pos % 8]) begin
            give(V_UNKNOWN);
          end else begin
            pos++;
            if (pos >= 8) open_header();
          end
        end
        PH_HDR: begin
          if (pos < 4) chunk_len = {chunk_len[23:0], b};
          else chunk_kind = {chunk_kind[23:0], b};
          pos++;
          if (pos >= 8) close_header();
        end
        PH_IHDR: begin
          if (pos == 9) colour = b;
          pos++;
          if (pos >= 13) begin
            if (colour == CT_GREY_A || colour == CT_RGBA) begin
              give(V_PRESENT);
            end else begin
              walk      = PH_SKIP;
              skip_left = CRC_BYTES;
            end
          end
        end
        default: begin
          if (skip_left != '0) skip_left = skip_left - 33'd1;
          if (skip_left == '0) open_header();
        end
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      if (!decided) begin
        bytes_walked++;
        walk_byte(b);
        if (!decided && eof) give(V_UNKNOWN);
      end
      if (eof) clear_file();
    endfunction

    function void check_verdict(logic [1:0] got);
      logic [1:0] want;
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: verdict %0d returned with none expected", $time, got);
      end else begin
        want = pending_verdicts.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: verdict mismatch, expected %0d, actual %0d", $time, want, got);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_verdict;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  alpha_verdict_board board;
  logic [7:0] file_q[$];
  bit         gaps_on = 1'b1;
  int         files_sent = 0;
  int         bytes_sent = 0;
  int         settings_used = 1;

  png_alpha_chunk_sniffer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_end_of_file (in_end_of_file),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_verdict    (out_verdict),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < 36);
  end

  // Requests and verdicts are taken at the edge on which they are accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_byte(in_data_byte, in_end_of_file);
      if (out_valid && !out_stall) board.check_verdict(out_verdict);
    end
  end

  function automatic void push_be32(logic [31:0] v);
    file_q.push_back(v[31:24]);
    file_q.push_back(v[23:16]);
    file_q.push_back(v[15:8]);
    file_q.push_back(v[7:0]);
  endfunction

  function automatic void push_header(logic [31:0] len, logic [31:0] kind);
    push_be32(len);
    push_be32(kind);
  endfunction

  function automatic void push_signature();
    int j;
    for (j = 0; j < 8; j++) file_q.push_back(PNG_MAGIC[j]);
  endfunction

  function automatic void push_random(int n);
    repeat (n) file_q.push_back(8'($urandom));
  endfunction

  // Four ASCII letters of mixed case, as an ancillary or private chunk would carry.
  function automatic logic [31:0] letter_kind();
    logic [31:0] k;
    int j;
    k = '0;
    for (j = 0; j < 4; j++) begin
      k = {k[23:0], 8'h41 + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00)};
    end
    return k;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof);
    while (gaps_on && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_file <= eof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_file();
    int i;
    for (i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    files_sent++;
    bytes_sent += file_q.size();
  endtask

  task automatic wait_drained(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_register(idx, value);
  endtask

  task automatic set_limits(input logic [31:0] chunks, input logic [31:0] max_offset);
    wait_drained(4);
    cfg_write(REG_MAX_CHUNKS, chunks);
    cfg_write(REG_MAX_OFFSET, max_offset);
    settings_used++;
  endtask

  // Mostly well-formed files with random content, the rest broken signatures and noise.
  task automatic run_phase(input int phase_bytes);
    int target;
    int shape;
    int idx;
    int keep;
    logic [31:0] len;
    logic [7:0] colour;
    target = bytes_sent + phase_bytes;
    while (bytes_sent < target) begin
      file_q.delete();
      shape = $urandom_range(0, 99);
      if (shape < 72) begin
        push_signature();
        if ($urandom_range(0, 9) < 8) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom : IHDR_LEN;
          push_header(len, KIND_IHDR);
          case ($urandom_range(0, 5))
            0: colour = 8'd0;
            1: colour = CT_TRUECOLOUR;
            2: colour = 8'd3;
            3: colour = CT_GREY_A;
            4: colour = CT_RGBA;
            default: colour = 8'($urandom);
          endcase
          push_random(9);
          file_q.push_back(colour);
          push_random(7);
        end
        repeat ($urandom_range(0, 3)) begin
          len = $urandom_range(0, 12);
          push_header(len, letter_kind());
          push_random(len + 4);
        end
        case ($urandom_range(0, 5))
          0: begin
            len = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
            push_header(len, KIND_TRNS);
            push_random(len + 4);
          end
          1: begin
            push_header($urandom_range(0, 20), KIND_IDAT);
            push_random($urandom_range(0, 6));
          end
          2: begin
            push_header(32'd0, KIND_IEND);
            push_random(4);
          end
          3: begin
            // A huge chunk that the file ends inside.
            push_header($urandom | 32'h8000_0000, letter_kind());
            push_random($urandom_range(0, 5));
          end
          4: ;
          default: push_header($urandom_range(0, 8), $urandom);
        endcase
        push_random($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0) begin
          keep = $urandom_range(1, file_q.size());
          while (file_q.size() > keep) void'(file_q.pop_back());
        end
      end else if (shape < 88) begin
        push_signature();
        idx = $urandom_range(0, 7);
        file_q[idx] = file_q[idx] ^ (8'h01 << $urandom_range(0, 7));
        push_random($urandom_range(0, 4));
      end else begin
        push_random($urandom_range(1, 10));
        if ($urandom_range(0, 1) == 1) file_q[0] = PNG_MAGIC[0];
      end
      send_file();
    end
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed files: bad signature, truncation, each deciding chunk but IEND and a huge skip.
    file_q = '{8'hFF};
    send_file();
    file_q = '{8'h89, 8'h50, 8'h4E};
    send_file();
    file_q.delete();
    push_signature();
    push_header(IHDR_LEN, KIND_IHDR);
    push_random(9);
    file_q.push_back(CT_RGBA);
    push_random(3);
    send_file();
    file_q.delete();
    push_signature();
    push_header(32'd0, KIND_TRNS);
    send_file();
    file_q.delete();
    push_signature();
    push_header(32'd1, KIND_TRNS);
    file_q.push_back(8'h00);
    send_file();
    file_q.delete();
    push_signature();
    push_header(IHDR_LEN, KIND_IHDR);
    push_random(9);
    file_q.push_back(CT_TRUECOLOUR);
    push_random(7);
    push_header(32'd0, KIND_IDAT);
    send_file();
    file_q.delete();
    push_signature();
    push_header(32'd14, KIND_IHDR);
    push_random(2);
    send_file();
    file_q.delete();
    push_signature();
    push_header(32'hFFFF_FFFF, letter_kind());
    push_random(3);
    send_file();

    run_phase(80);
    set_limits(32'd1, 32'hFFFF_FFFF);
    run_phase(80);
    set_limits(32'd65535, 32'd0);
    run_phase(70);
    gaps_on = 1'b0;
    set_limits(32'd3, 32'd40);
    run_phase(90);
    gaps_on = 1'b1;
    set_limits(32'd2, 32'd8);
    run_phase(80);
    set_limits($urandom_range(1, 6), $urandom_range(8, 80));
    run_phase(80);
    set_limits(32'(MAX_CHUNKS_RST), MAX_OFFSET_RST);
    run_phase(40);

    wait_drained(16);
    $display("Sent %0d files (%0d bytes, %0d walked) under %0d limit settings.",
             files_sent, bytes_sent, board.bytes_walked, settings_used);
    $display("Checked %0d verdicts: %0d unknown, %0d absent, %0d present.",
             board.verdicts_seen, board.tally[V_UNKNOWN], board.tally[V_ABSENT],
             board.tally[V_PRESENT]);
    if (board.mismatches == 0 && board.pending_verdicts.size() == 0) begin
      $display("PASS png_alpha_chunk_sniffer");
    end else begin
      $display("FAIL png_alpha_chunk_sniffer");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d verdicts outstanding.", board.pending_verdicts.size());
    $display("FAIL png_alpha_chunk_sniffer");
    $finish;
  end

endmodule
